>>> sv/assert_macros.svh
// Assertion helpers; every user has clk and active-low rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds on every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/tcgp_pkg.sv
package tcgp_pkg;

  localparam int COL_W   = 5;
  localparam int LINE_W  = 3;
  localparam int X_W     = 7;
  localparam int Y_W     = 6;
  localparam int GLYPH_W = 7;

  // Result command codes
  typedef enum logic [1:0] {
    CMD_DRAW      = 2'd0,
    CMD_PAGE_FULL = 2'd1,
    CMD_CLEAR     = 2'd2,
    CMD_FLUSH     = 2'd3
  } cmd_t;

  // Input opcodes
  localparam logic OP_PLACE = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Character codes
  localparam logic [7:0] CH_BS         = 8'h08;
  localparam logic [7:0] CH_LF         = 8'h0A;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_FIRST_PRNT = 8'h20;
  localparam logic [7:0] CH_LAST_PRNT  = 8'h7E;
  localparam logic [GLYPH_W-1:0] GLYPH_SPACE = 7'h20;

  // Up to three results per request: head (page full or clear), draw, flush
  typedef struct packed {
    logic                head_v;
    cmd_t                head_cmd;
    logic                draw_v;
    logic [X_W-1:0]      x;
    logic [Y_W-1:0]      y;
    logic [GLYPH_W-1:0]  glyph;
    logic                flush_v;
  } bundle_t;

endpackage

>>> sv/tcgp_cursor.sv
module tcgp_cursor #(
  parameter int COLUMNS     = 21,
  parameter int ROWS        = 6,
  parameter int CELL_WIDTH  = 6,
  parameter int CELL_HEIGHT = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  input  logic              in_fire,
  input  logic              opcode,
  input  logic [7:0]        char_code,
  input  logic              end_of_string,
  output tcgp_pkg::bundle_t bundle
);
  import tcgp_pkg::*;

  `include "assert_macros.svh"

  localparam logic [COL_W-1:0]  COLS_C = COL_W'(COLUMNS);
  localparam logic [LINE_W:0]   ROWS_C = (LINE_W+1)'(ROWS);
  localparam int                PW     = 10;

  logic              enable_r;
  logic [COL_W-1:0]  col_r, col_nxt, col0, draw_col;
  logic [LINE_W-1:0] line_r, line_nxt, line0, draw_line;
  logic [LINE_W:0]   line_inc;
  logic              wrap, is_cr, is_lf, printable;
  logic [PW-1:0]     x_full, y_full;

  assign line_inc  = {1'b0, line_r} + (LINE_W+1)'(1);
  assign wrap      = (col_r >= COLS_C);
  assign is_cr     = (char_code == CH_CR);
  assign is_lf     = (char_code == CH_LF);
  assign printable = (char_code >= CH_FIRST_PRNT) && (char_code <= CH_LAST_PRNT);

  // Cursor update and result selection for one request
  always_comb begin
    col_nxt   = col_r;
    line_nxt  = line_r;
    col0      = col_r;
    line0     = line_r;
    draw_col  = col_r;
    draw_line = line_r;
    bundle          = '0;
    bundle.head_cmd = CMD_CLEAR;
    bundle.glyph    = GLYPH_SPACE;
    if (enable_r) begin
      if (opcode == OP_CLEAR) begin
        col_nxt       = '0;
        line_nxt      = '0;
        bundle.head_v = 1'b1;
      end else begin
        if (char_code == CH_BS) begin
          // erase previous cell, stepping back over a line break
          if (col_r != '0 || line_r != '0) begin
            if (col_r == '0) begin
              col_nxt  = COLS_C - COL_W'(1);
              line_nxt = line_r - LINE_W'(1);
            end else begin
              col_nxt = col_r - COL_W'(1);
            end
            bundle.draw_v = 1'b1;
            draw_col      = col_nxt;
            draw_line     = line_nxt;
          end
        end else begin
          // wrap or LF moves down; CR or wrap returns home
          if (wrap || is_cr) col0 = '0;
          if (wrap || is_lf) begin
            if (line_inc >= ROWS_C) begin
              bundle.head_v   = 1'b1;
              bundle.head_cmd = CMD_PAGE_FULL;
              line0           = '0;
            end else begin
              line0 = line_inc[LINE_W-1:0];
            end
          end
          col_nxt  = col0;
          line_nxt = line0;
          if (!is_cr && !is_lf && printable) begin
            bundle.draw_v = 1'b1;
            bundle.glyph  = char_code[GLYPH_W-1:0];
            draw_col      = col0;
            draw_line     = line0;
            col_nxt       = col0 + COL_W'(1);
          end
        end
        bundle.flush_v = end_of_string;
      end
    end
    x_full   = PW'(draw_col) * PW'(CELL_WIDTH);
    y_full   = PW'(draw_line) * PW'(CELL_HEIGHT) + PW'(CELL_HEIGHT - 1);
    bundle.x = x_full[X_W-1:0];
    bundle.y = y_full[Y_W-1:0];
  end

  // Cursor and enable registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b1;
      col_r    <= '0;
      line_r   <= '0;
    end else begin
      if (cfg_wr_en) enable_r <= cfg_wr_data;
      if (in_fire) begin
        col_r  <= col_nxt;
        line_r <= line_nxt;
      end
    end
  end

  `ASSERT_ALWAYS(a_col_range, col_r <= COLS_C, "cursor column past limit")
  `ASSERT_ALWAYS(a_line_range, {1'b0, line_r} < ROWS_C, "cursor line past last row")
  `ASSERT_IMPLY(a_draw_glyph, bundle.draw_v,
                bundle.glyph >= 7'h20 && bundle.glyph <= 7'h7E, "unprintable glyph drawn")

endmodule

>>> sv/tcgp_out.sv
module tcgp_out (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  tcgp_pkg::bundle_t bundle,
  output logic              in_ready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [23:0]       out_tdata,
  output logic [1:0]        out_tuser,
  output logic              out_tlast
);
  import tcgp_pkg::*;

  `include "assert_macros.svh"

  bundle_t     bundle_r;
  logic [2:0]  pend_r, pend_nxt, new_pend, sel, rest;
  logic        take;
  cmd_t        cmd;

  // pending slots: bit 0 head, bit 1 draw, bit 2 flush
  assign new_pend   = {bundle.flush_v, bundle.draw_v, bundle.head_v};
  assign sel        = pend_r & (~pend_r + 3'd1);
  assign rest       = pend_r & ~sel;
  assign out_tvalid = (pend_r != 3'b000);
  assign out_tlast  = (rest == 3'b000);
  assign take       = out_tvalid && out_tready;
  assign in_ready   = !out_tvalid || (out_tready && out_tlast);

  // Drive the selected slot
  always_comb begin
    priority if (sel[0]) cmd = bundle_r.head_cmd;
    else if (sel[1])     cmd = CMD_DRAW;
    else                 cmd = CMD_FLUSH;
    out_tuser = cmd;
    if (sel[1]) out_tdata = {4'b0, bundle_r.glyph, bundle_r.y, bundle_r.x};
    else        out_tdata = {4'b0, GLYPH_SPACE, {Y_W{1'b0}}, {X_W{1'b0}}};
  end

  // Load a new bundle or retire the slot just sent
  always_comb begin
    pend_nxt = pend_r;
    if (take) pend_nxt = rest;
    if (in_fire) pend_nxt = new_pend;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) bundle_r <= bundle;
  end

  `ASSERT_NEXT(a_load_shows, in_fire && new_pend != 3'b000, out_tvalid,
               "accepted request lost its results")
  `ASSERT_IMPLY(a_no_overrun, in_fire, !out_tvalid || (take && out_tlast),
                "request accepted over pending results")
  `ASSERT_NEXT(a_drain_done, take && out_tlast && !in_fire, !out_tvalid,
               "result repeated after last")

endmodule

>>> sv/text_cursor_glyph_placer.sv
// Channel   Dir  Ports                  Content
// in_       in   tvalid/tready/tdata    character request; tuser opcode, tlast end of string
// out_      out  tvalid/tready/tdata    drawing command; tuser command, tlast last result
// cfg_      in   wr_en/wr_data          print_enable
//
// A request is decoded in the cycle it is accepted; the cursor registers and the
// result register load at that edge, and results leave one per cycle from the next while
// out_tready is high. A request with one result or none is taken every cycle unless the
// output stalls; with more, the next waits while the single output port drains them.
// Reset (synchronous, rst_n low) homes the cursor and sets print_enable.
// A stalled output holds its result and blocks new requests until the last is taken.
module text_cursor_glyph_placer #(
  parameter int COLUMNS     = 21,
  parameter int ROWS        = 6,
  parameter int CELL_WIDTH  = 6,
  parameter int CELL_HEIGHT = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tuser,   // [0] opcode
  input  logic        in_tlast,   // end_of_string
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [6:0] pixel_x, [12:7] pixel_y, [19:13] glyph, zero pad
  output logic [1:0]  out_tuser,  // [1:0] command
  output logic        out_tlast   // last_result
);
  import tcgp_pkg::*;

  bundle_t bundle;
  logic    in_fire;

  assign in_fire = in_tvalid && in_tready;

  // cursor state and per-request decode
  tcgp_cursor #(
    .COLUMNS     (COLUMNS),
    .ROWS        (ROWS),
    .CELL_WIDTH  (CELL_WIDTH),
    .CELL_HEIGHT (CELL_HEIGHT)
  ) u_cursor (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_fire       (in_fire),
    .opcode        (in_tuser),
    .char_code     (in_tdata),
    .end_of_string (in_tlast),
    .bundle        (bundle)
  );

  // result register and serializer
  tcgp_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .bundle     (bundle),
    .in_ready   (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
